### rtl/u2da_pkg.sv
// Shared constants and types for the unsigned-to-decimal ASCII converter.
package u2da_pkg;

	localparam int VALUE_BITS = 32;
	// Decimal digits of the largest value: floor(bits * log10(2)) + 1
	localparam int DIGITS     = ((VALUE_BITS * 1233) >> 12) + 1;
	localparam int BCD_W      = DIGITS * 4;
	localparam int CNT_W      = $clog2(VALUE_BITS);
	localparam int REM_W      = $clog2(DIGITS + 1);
	localparam int IN_BYTES   = (VALUE_BITS + 7) / 8;

	localparam logic [5:0] ASCII_ZERO = 6'd48;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SKIP = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

endpackage

### rtl/unsigned_to_decimal_ascii.sv
// Top level: unsigned binary to decimal ASCII digit stream, double-dabble based.
//
// Input channel (s_*): one word per number, s_tdata holds the unsigned value.
// Output channel (m_*): one word per decimal digit, most significant first,
// no leading zeros; m_tdata holds the ASCII code, m_tlast marks the final
// digit. Zero gives the single character '0' with m_tlast set.
//
// One shift-and-add-3 unit adjusts every BCD digit and shifts in one binary
// bit per cycle until all VALUE_BITS bits are in. Leading zero digits are
// then dropped one per cycle, the block moves to sending, and the remaining
// digits are sent one per cycle while m_tready is high.
// s_tready is high only while idle; one number is in work at a time.
// A stall on m_tready holds the current digit on the port until taken.
// Reset returns the block to idle with no digit pending.
module unsigned_to_decimal_ascii (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [u2da_pkg::IN_BYTES*8-1:0]      s_tdata,   // [VALUE_BITS-1:0] value
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [7:0]                           m_tdata,   // [5:0] digit_char, [7:6] zero
	output logic                                 m_tlast    // last
);
	import u2da_pkg::*;

	state_t                  state_q;
	logic [VALUE_BITS-1:0]   bin_q;
	logic [BCD_W-1:0]        bcd_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [REM_W-1:0]        rem_q;
	logic [BCD_W-1:0]        bcd_adj;
	logic [3:0]              top_dig;
	logic                    s_acc;
	logic                    m_acc;

	// Add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	assign top_dig  = bcd_q[BCD_W-1 -: 4];
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tdata  = {2'b00, ASCII_ZERO + {2'b00, top_dig}};
	assign m_tlast  = (rem_q == REM_W'(1));
	assign s_acc    = s_tvalid && s_tready;
	assign m_acc    = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= ST_CONV;
						cnt_q   <= CNT_W'(VALUE_BITS - 1);
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= ST_SKIP;
						rem_q   <= REM_W'(DIGITS);
					end
				end
				ST_SKIP: begin
					// drop a leading zero, but keep at least one digit
					if (top_dig == 4'd0 && rem_q != REM_W'(1)) begin
						rem_q <= rem_q - REM_W'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (m_acc) begin
						rem_q <= rem_q - REM_W'(1);
						if (rem_q == REM_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					bin_q <= s_tdata[VALUE_BITS-1:0];
					bcd_q <= '0;
				end
			end
			ST_CONV: begin
				bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
				bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			end
			ST_SKIP: begin
				if (top_dig == 4'd0 && rem_q != REM_W'(1)) begin
					bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
				end
			end
			ST_EMIT: begin
				if (m_acc) begin
					bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
				end
			end
			default: begin
				bcd_q <= bcd_q;
			end
		endcase
	end

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (top_dig <= 4'd9))
		else $error("converted digit out of decimal range");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input accepted while digits pending");

	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && $past(state_q == ST_SKIP)
		|-> (top_dig != 4'd0 || rem_q == REM_W'(1)))
		else $error("leading zero digit emitted");

	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP || state_q == ST_EMIT) |-> (rem_q != '0))
		else $error("digit count underflow");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_acc && m_tlast) |=> (state_q == ST_IDLE))
		else $error("block not idle after final digit");

endmodule
